### rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int NUM_LIMBS_DEF = 6;
  localparam int LIMB_BITS_DEF = 64;
  localparam int NL = 6;
  localparam int LB = 64;
  localparam int WL = 2 * NL;

  typedef logic [LB-1:0] limb_t;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    limb_t      a_limb;
    limb_t      b_limb;
  } in_word_t;

  typedef struct packed {
    limb_t result_limb;
    logic  last;
  } out_word_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLR,      // clear wide store and carry
    OP_MAC,      // acc[i+j] (+)= x[i]*y[j] + carry, select by src
    OP_HI,       // write carry into acc[i+j]
    OP_ADDSUB,   // one limb of add/sub of operands into result
    OP_FIX,      // one limb of conditional correction of result
    OP_FINAL,    // one limb of T + m*p, take upper half
    OP_ZERO      // clear result limb
  } op_t;

  typedef enum logic [1:0] {
    SRC_TT,   // x = a, y = b, acc = wide store
    SRC_M,    // x = wide[i], y = np[j], acc = m
    SRC_MP    // x = m, y = p, acc = mp
  } src_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLR,
    ST_MAC,
    ST_HI,
    ST_ADDSUB,
    ST_CHECK,
    ST_FIX,
    ST_FINAL,
    ST_ZERO,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t        op;
    src_t       src;
    logic [2:0] i;
    logic [2:0] j;
    logic [1:0] part;      // MAC: which 32x32 partial product this cycle
    logic       fix_sub;   // FIX: subtract p (1) or add p (0)
    logic       carry_clr; // clear carry before this step
  } dp_cmd_t;

  typedef struct packed {
    logic need_fix;
    logic borrow;
  } dp_stat_t;

  function automatic limb_t p_limb(input logic [2:0] k);
    case (k)
      3'd0: p_limb = 64'd13402431016077863595;
      3'd1: p_limb = 64'd2210141511517208575;
      3'd2: p_limb = 64'd7435674573564081700;
      3'd3: p_limb = 64'd7239337960414712511;
      3'd4: p_limb = 64'd5412103778470702295;
      3'd5: p_limb = 64'd1873798617647539866;
      default: p_limb = '0;
    endcase
  endfunction

  function automatic limb_t np_limb(input logic [2:0] k);
    case (k)
      3'd0: np_limb = 64'd9940570264628428797;
      3'd1: np_limb = 64'd2912381532814513128;
      3'd2: np_limb = 64'd1652591199965612872;
      3'd3: np_limb = 64'd1868090109324352332;
      3'd4: np_limb = 64'd7544399084751736664;
      3'd5: np_limb = 64'd14893510650384546964;
      default: np_limb = '0;
    endcase
  endfunction

endpackage

### rtl/core/bfa_datapath.sv
`timescale 1ns / 1ps
module bfa_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [2:0]        load_idx,
  input  bfa_pkg::limb_t    a_in,
  input  bfa_pkg::limb_t    b_in,
  input  bfa_pkg::dp_cmd_t  cmd,
  input  logic              sub_mode,
  input  logic [2:0]        rd_idx,
  output bfa_pkg::limb_t    rd_data,
  output bfa_pkg::dp_stat_t stat
);
  import bfa_pkg::*;

  limb_t a_r [NL];
  limb_t b_r [NL];
  limb_t t_r [WL];
  limb_t m_r [NL];
  limb_t mp_r [WL];
  limb_t res_r [NL];
  limb_t carry_r, carry_nxt;
  logic  top_r, top_nxt;
  logic  gt_r, gt_nxt, eq_r, eq_nxt;
  logic [127:0] prod_r, prod_nxt;

  logic [3:0]   k;
  limb_t        x, y, acc;
  logic [31:0]  xh, yh;
  logic [63:0]  pp;
  logic [127:0] pp_sh, sum;
  limb_t        cin;
  logic [64:0]  s_ab, s_fx, s_fin;
  limb_t        pk, ak, bk;
  logic         c1;

  assign k   = {1'b0, cmd.i} + {1'b0, cmd.j};
  assign cin = cmd.carry_clr ? '0 : carry_r;
  assign c1  = cin[0];
  assign pk  = p_limb(cmd.i);
  assign ak  = a_r[cmd.i];
  assign bk  = b_r[cmd.i];

  // Select multiplier sources
  always_comb begin
    case (cmd.src)
      SRC_TT: begin
        x = a_r[cmd.i]; y = b_r[cmd.j]; acc = t_r[k];
      end
      SRC_M: begin
        x = t_r[cmd.i]; y = np_limb(cmd.j); acc = m_r[k[2:0]];
      end
      SRC_MP: begin
        x = m_r[cmd.i]; y = p_limb(cmd.j); acc = mp_r[k];
      end
      default: begin
        x = '0; y = '0; acc = '0;
      end
    endcase
  end

  // Build the limb product from four 32x32 partial products, one per cycle
  assign xh = cmd.part[1] ? x[63:32] : x[31:0];
  assign yh = cmd.part[0] ? y[63:32] : y[31:0];
  assign pp = {32'd0, xh} * {32'd0, yh};

  always_comb begin
    case (cmd.part)
      2'd0: pp_sh = {64'd0, pp};
      2'd3: pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign prod_nxt = ((cmd.part == 2'd0) ? 128'd0 : prod_r) + pp_sh;
  assign sum   = prod_nxt + {64'd0, acc} + {64'd0, cin};
  assign s_ab  = sub_mode ? ({1'b0, ak} - {1'b0, bk} - {64'd0, c1})
                          : ({1'b0, ak} + {1'b0, bk} + {64'd0, c1});
  assign s_fx  = cmd.fix_sub ? ({1'b0, res_r[cmd.i]} - {1'b0, pk} - {64'd0, c1})
                             : ({1'b0, res_r[cmd.i]} + {1'b0, pk} + {64'd0, c1});
  assign s_fin = {1'b0, t_r[k]} + {1'b0, mp_r[k]} + {64'd0, c1};

  // Compare of a new limb against p, built from least significant upward
  function automatic logic [1:0] cmp_step(input limb_t v, input limb_t pv,
                                         input logic g, input logic e);
    logic ng, ne;
    begin
      ng = (v > pv) || ((v == pv) && g);
      ne = (v == pv) && e;
      cmp_step = {ng, ne};
    end
  endfunction

  always_comb begin
    carry_nxt = carry_r;
    top_nxt   = top_r;
    gt_nxt    = gt_r;
    eq_nxt    = eq_r;
    case (cmd.op)
      OP_CLR: begin
        carry_nxt = '0; top_nxt = 1'b0;
      end
      OP_MAC: if (cmd.part == 2'd3) carry_nxt = sum[127:64];
      OP_HI: carry_nxt = '0;
      OP_ADDSUB: begin
        carry_nxt = {63'd0, s_ab[64]};
        {gt_nxt, eq_nxt} = cmp_step(s_ab[63:0], pk,
                                    (cmd.i == 3'd0) ? 1'b0 : gt_r,
                                    (cmd.i == 3'd0) ? 1'b1 : eq_r);
        if (cmd.i == 3'd5) top_nxt = s_ab[64];
      end
      OP_FIX: carry_nxt = {63'd0, s_fx[64]};
      OP_FINAL: begin
        carry_nxt = {63'd0, s_fin[64]};
        if (k >= 4'(NL)) begin
          {gt_nxt, eq_nxt} = cmp_step(s_fin[63:0], p_limb(k[2:0] - 3'd6),
                                      (k == 4'(NL)) ? 1'b0 : gt_r,
                                      (k == 4'(NL)) ? 1'b1 : eq_r);
        end
        if (k == 4'(WL - 1)) top_nxt = s_fin[64];
      end
      default: ;
    endcase
  end

  // Registers and stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
      top_r   <= 1'b0;
      gt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
      top_r   <= top_nxt;
      gt_r    <= gt_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r[load_idx] <= a_in;
      b_r[load_idx] <= b_in;
    end
    case (cmd.op)
      OP_CLR: begin
        for (int n = 0; n < WL; n++) begin
          t_r[n]  <= '0;
          mp_r[n] <= '0;
        end
        for (int n = 0; n < NL; n++) m_r[n] <= '0;
      end
      OP_MAC: begin
        prod_r <= prod_nxt;
        if (cmd.part == 2'd3) begin
          case (cmd.src)
            SRC_TT: t_r[k] <= sum[63:0];
            SRC_M: m_r[k[2:0]] <= sum[63:0];
            default: mp_r[k] <= sum[63:0];
          endcase
        end
      end
      OP_HI: begin
        if (cmd.src == SRC_TT) t_r[k] <= carry_r;
        else mp_r[k] <= carry_r;
      end
      OP_ADDSUB: res_r[cmd.i] <= s_ab[63:0];
      OP_FIX: res_r[cmd.i] <= s_fx[63:0];
      OP_FINAL: if (k >= 4'(NL)) res_r[k[2:0] - 3'd6] <= s_fin[63:0];
      OP_ZERO: res_r[cmd.i] <= '0;
      default: ;
    endcase
  end

  assign rd_data       = res_r[rd_idx];
  assign stat.need_fix = top_r || gt_r || eq_r;
  assign stat.borrow   = top_r;
endmodule

### rtl/core/bfa_ctrl.sv
`timescale 1ns / 1ps
module bfa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [1:0]       in_cmd,
  input  logic             out_fire,
  input  bfa_pkg::dp_stat_t stat,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic [2:0]       load_idx,
  output logic [2:0]       rd_idx,
  output logic             sub_mode,
  output bfa_pkg::dp_cmd_t cmd
);
  import bfa_pkg::*;

  state_t     st_r, st_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] i_r, i_nxt, j_r, j_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] part_r, part_nxt;
  cmd_t       op_r, op_nxt;

  assign load_idx = cnt_r;
  assign rd_idx   = cnt_r;
  assign sub_mode = (op_r == CMD_SUB);

  // Next state
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r;
    phase_nxt = phase_r; op_nxt = op_r; part_nxt = part_r;
    case (st_r)
      ST_LOAD: if (in_fire) begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          cnt_nxt = '0; i_nxt = '0; j_nxt = '0; phase_nxt = '0;
          part_nxt = '0;
          op_nxt = cmd_t'(in_cmd);
          case (cmd_t'(in_cmd))
            CMD_ADD, CMD_SUB: st_nxt = ST_ADDSUB;
            CMD_MUL: st_nxt = ST_CLR;
            default: st_nxt = ST_ZERO;
          endcase
        end
      end
      ST_CLR: st_nxt = ST_MAC;
      ST_MAC: begin
        // Hold the limb product for its four partial products
        if (part_r != 2'd3) begin
          part_nxt = part_r + 2'd1;
        end else begin
          part_nxt = '0;
          if (phase_r == 2'd1) begin
            // m = T low * np mod R: triangle j < NL - i
            if (j_r == 3'd5 - i_r) begin
              j_nxt = '0;
              if (i_r == 3'd5) begin
                i_nxt = '0; phase_nxt = 2'd2;
              end else i_nxt = i_r + 3'd1;
            end else j_nxt = j_r + 3'd1;
          end else if (j_r == 3'd5) begin
            j_nxt = '0; st_nxt = ST_HI;
          end else j_nxt = j_r + 3'd1;
        end
      end
      ST_HI: begin
        if (i_r == 3'd5) begin
          i_nxt = '0;
          if (phase_r == 2'd0) begin
            phase_nxt = 2'd1; st_nxt = ST_MAC;
          end else st_nxt = ST_FINAL;
        end else begin
          i_nxt = i_r + 3'd1; st_nxt = ST_MAC;
        end
      end
      ST_FINAL: begin
        if (j_r == 3'd5) begin
          j_nxt = '0;
          if (i_r == 3'd1) begin
            i_nxt = '0; st_nxt = ST_CHECK;
          end else i_nxt = 3'd1;
        end else j_nxt = j_r + 3'd1;
      end
      ST_ADDSUB: if (i_r == 3'd5) begin
        i_nxt = '0; st_nxt = ST_CHECK;
      end else i_nxt = i_r + 3'd1;
      ST_CHECK: begin
        if ((op_r == CMD_SUB) ? stat.borrow : stat.need_fix) st_nxt = ST_FIX;
        else st_nxt = ST_EMIT;
      end
      ST_FIX: if (i_r == 3'd5) begin
        i_nxt = '0; st_nxt = ST_EMIT;
      end else i_nxt = i_r + 3'd1;
      ST_ZERO: if (i_r == 3'd5) begin
        i_nxt = '0; st_nxt = ST_EMIT;
      end else i_nxt = i_r + 3'd1;
      ST_EMIT: if (out_fire) begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          cnt_nxt = '0; st_nxt = ST_LOAD;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
    // FINAL walks k = 0..11 as (i, j) with i in {0,1}: remap below
  end

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.op = OP_IDLE;
    cmd.src = SRC_TT;
    cmd.i = i_r;
    cmd.j = j_r;
    in_ready_o  = (st_r == ST_LOAD);
    out_valid_o = (st_r == ST_EMIT);
    case (st_r)
      ST_CLR: cmd.op = OP_CLR;
      ST_MAC: begin
        cmd.op = OP_MAC;
        cmd.src = (phase_r == 2'd0) ? SRC_TT :
                  (phase_r == 2'd1) ? SRC_M : SRC_MP;
        cmd.part = part_r;
        cmd.carry_clr = (j_r == 3'd0);
      end
      ST_HI: begin
        cmd.op = OP_HI;
        cmd.src = (phase_r == 2'd0) ? SRC_TT : SRC_MP;
        cmd.j = 3'd6; // k = i + 6
      end
      ST_FINAL: begin
        // k = 6*i + j for i in 0..1 handled as i + j with i stepping by 6
        cmd.op = OP_FINAL;
        cmd.i = (i_r == 3'd0) ? 3'd0 : 3'd6;
        cmd.j = j_r;
        cmd.carry_clr = (i_r == 3'd0) && (j_r == 3'd0);
      end
      ST_ADDSUB: begin
        cmd.op = OP_ADDSUB;
        cmd.carry_clr = (i_r == 3'd0);
      end
      ST_FIX: begin
        cmd.op = OP_FIX;
        cmd.fix_sub = (op_r != CMD_SUB);
        cmd.carry_clr = (i_r == 3'd0);
      end
      ST_ZERO: cmd.op = OP_ZERO;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD; cnt_r <= '0; i_r <= '0; j_r <= '0;
      phase_r <= '0; part_r <= '0; op_r <= CMD_ADD;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; i_r <= i_nxt; j_r <= j_nxt;
      phase_r <= phase_nxt; part_r <= part_nxt;
      op_r <= op_nxt;
    end
  end
endmodule

### rtl/core/bls12_381_base_field_alu_top.sv
`timescale 1ns / 1ps
// Modular add, subtract and Montgomery multiply (R = 2^384) over the
// BLS12-381 base field. Send six words, limbs least significant first; the
// command on the sixth word picks the operation. The block then returns six
// result words, the last one flagged. The block is ready for input words
// throughout loading. Add and subtract apply the correction by p when the
// result needs it; the unused command returns a zero result. Multiply uses
// the single 32x32 multiplier that builds each 64x64 limb product from four
// partial products while walking a*b, the Montgomery factor and m*p one limb
// product at a time, with the final subtraction when needed. Input is held
// off until all six result words are taken.
module bls12_381_base_field_alu_top #(
  parameter int NUM_LIMBS = bfa_pkg::NUM_LIMBS_DEF,
  parameter int LIMB_BITS = bfa_pkg::LIMB_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bfa_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bfa_pkg::out_word_t out_data
);
  import bfa_pkg::*;

  logic       in_fire, out_fire;
  logic [2:0] load_idx, rd_idx;
  logic       sub_mode;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  limb_t      rd_data;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  bfa_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_cmd(in_data.command), .out_fire, .stat,
    .in_ready_o(in_ready), .out_valid_o(out_valid), .load_idx, .rd_idx,
    .sub_mode, .cmd
  );

  bfa_datapath u_dp (
    .clk, .rst_n, .load(in_fire), .load_idx, .a_in(in_data.a_limb),
    .b_in(in_data.b_limb), .cmd, .sub_mode, .rd_idx, .rd_data, .stat
  );

  assign out_data.result_limb = rd_data;
  assign out_data.last = (rd_idx == 3'(NUM_LIMBS - 1)) && (LIMB_BITS == LB);

  // Never load and emit together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("load and emit overlap");
  // Output word held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // Last word returns to loading
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_data.last |=> in_ready) else $error("no return to load");
endmodule
